### hw/rtl/cppm_frame_decoder_assert.svh
// Assertion helpers for the CPPM frame decoder.
// Each one checks on the rising edge of clk and is quiet while rst_n is low.
`ifndef CPPM_FRAME_DECODER_ASSERT_SVH
`define CPPM_FRAME_DECODER_ASSERT_SVH

// Same-cycle implication.
`define CFD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/cfd_pkg.sv
`default_nettype none
package cfd_pkg;

  localparam int MAX_CHANNELS = 8;
  // Frames never exceed eight channels, whatever the store could hold.
  localparam int STORE_CAP = (MAX_CHANNELS < 8) ? MAX_CHANNELS : 8;
  localparam int IDX_W = (STORE_CAP > 1) ? $clog2(STORE_CAP) : 1;
  localparam int CNT_W = $clog2(STORE_CAP + 1);

  localparam int VAL_W     = 16;
  localparam int ACT_W     = 2;
  localparam int CFG_IDX_W = 2;
  localparam int OIDX_W    = 3;
  localparam int OCNT_W    = 4;

  localparam logic [ACT_W-1:0] ACT_PULSE    = 2'd0;
  localparam logic [ACT_W-1:0] ACT_OVERFLOW = 2'd1;
  localparam logic [ACT_W-1:0] ACT_FALL     = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_MIN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INPUT_MIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INPUT_MAX = 2'd2;

  localparam logic [VAL_W-1:0] SYNC_MIN_RST  = 16'd3000;
  localparam logic [VAL_W-1:0] INPUT_MIN_RST = 16'd800;
  localparam logic [VAL_W-1:0] INPUT_MAX_RST = 16'd2200;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD
  } state_t;

  typedef struct packed {
    logic [VAL_W-1:0] sync_min;
    logic [VAL_W-1:0] input_min;
    logic [VAL_W-1:0] input_max;
  } cfg_t;

  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [VAL_W-1:0] wr_data;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
  } ram_req_t;

  typedef struct packed {
    logic              valid;
    logic [OIDX_W-1:0] index;
    logic [OCNT_W-1:0] frame_n;
    logic              last;
  } load_t;

  typedef struct packed {
    logic busy;
    logic count_zero;
  } stat_t;

endpackage
`default_nettype wire

### hw/rtl/cfd_ram.sv
`default_nettype none
module cfd_ram #(
  parameter int DEPTH = 8,
  parameter int WIDTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

### hw/rtl/cfd_ctrl.sv
`default_nettype none
module cfd_ctrl (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire cfd_pkg::cfg_t                cfg,
  input  wire logic                         in_valid,
  input  wire logic [cfd_pkg::ACT_W-1:0]    in_action,
  input  wire logic [cfd_pkg::VAL_W-1:0]    in_pulse_width,
  input  wire logic [cfd_pkg::VAL_W-1:0]    in_pulse_period,
  input  wire logic                         out_free,
  output cfd_pkg::ram_req_t                 ram_req,
  output cfd_pkg::load_t                    load,
  output cfd_pkg::stat_t                    stat
);

  cfd_pkg::state_t                state_r, state_nxt;
  logic [cfd_pkg::CNT_W-1:0]      count_r, count_nxt;
  logic                           ovf_r, ovf_nxt;
  logic [cfd_pkg::CNT_W-1:0]      frame_n_r, frame_n_nxt;
  logic [cfd_pkg::IDX_W-1:0]      rd_idx_r, rd_idx_nxt;
  logic                           in_fire;
  logic                           last;
  logic                           in_window;

  assign in_fire   = in_valid && (state_r == cfd_pkg::ST_IDLE);
  assign last      = (cfd_pkg::CNT_W'(rd_idx_r) + cfd_pkg::CNT_W'(1)) == frame_n_r;
  assign in_window = (in_pulse_period >= cfg.input_min) &&
                     (in_pulse_period <= cfg.input_max);

  assign stat.busy       = (state_r != cfd_pkg::ST_IDLE);
  assign stat.count_zero = (count_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= cfd_pkg::ST_IDLE;
      count_r   <= '0;
      ovf_r     <= 1'b0;
      frame_n_r <= '0;
      rd_idx_r  <= '0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      ovf_r     <= ovf_nxt;
      frame_n_r <= frame_n_nxt;
      rd_idx_r  <= rd_idx_nxt;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    ovf_nxt         = ovf_r;
    frame_n_nxt     = frame_n_r;
    rd_idx_nxt      = rd_idx_r;
    ram_req.wr_en   = 1'b0;
    ram_req.wr_addr = count_r[cfd_pkg::IDX_W-1:0];
    ram_req.wr_data = in_pulse_period;
    ram_req.rd_en   = 1'b0;
    ram_req.rd_addr = rd_idx_r;
    load.valid      = 1'b0;
    load.index      = cfd_pkg::OIDX_W'(rd_idx_r);
    load.frame_n    = cfd_pkg::OCNT_W'(frame_n_r);
    load.last       = last;
    case (state_r)
      cfd_pkg::ST_IDLE: begin
        if (in_fire) begin
          case (in_action)
            cfd_pkg::ACT_PULSE: begin
              if (ovf_r) begin
                count_nxt = '0;
              end else if (in_pulse_width >= cfg.sync_min) begin
                if (count_r != '0) begin
                  frame_n_nxt = count_r;
                  count_nxt   = '0;
                  rd_idx_nxt  = '0;
                  state_nxt   = cfd_pkg::ST_READ;
                end
              end else if (in_window) begin
                // Drop the period once the store is full.
                if (count_r < cfd_pkg::CNT_W'(cfd_pkg::STORE_CAP)) begin
                  ram_req.wr_en = 1'b1;
                  count_nxt     = count_r + cfd_pkg::CNT_W'(1);
                end
              end else begin
                count_nxt = '0;
              end
              ovf_nxt = 1'b0;
            end
            cfd_pkg::ACT_OVERFLOW: begin
              ovf_nxt = 1'b1;
            end
            cfd_pkg::ACT_FALL: begin
              if (ovf_r) begin
                count_nxt = '0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      cfd_pkg::ST_READ: begin
        ram_req.rd_en = 1'b1;
        state_nxt     = cfd_pkg::ST_LOAD;
      end
      cfd_pkg::ST_LOAD: begin
        // Hold the read data until the output slot frees up.
        if (out_free) begin
          load.valid = 1'b1;
          if (last) begin
            state_nxt = cfd_pkg::ST_IDLE;
          end else begin
            rd_idx_nxt = rd_idx_r + cfd_pkg::IDX_W'(1);
            state_nxt  = cfd_pkg::ST_READ;
          end
        end
      end
      default: begin
        state_nxt = cfd_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

### hw/rtl/cfd_out.sv
`default_nettype none
module cfd_out (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire cfd_pkg::load_t                load,
  input  wire logic [cfd_pkg::VAL_W-1:0]     rd_data,
  input  wire logic                          out_stall,
  output logic                               out_free,
  output logic                               out_valid,
  output logic      [cfd_pkg::OIDX_W-1:0]    out_channel_index,
  output logic      [cfd_pkg::VAL_W-1:0]     out_channel_value,
  output logic      [cfd_pkg::OCNT_W-1:0]    out_frame_channels,
  output logic                               out_last_in_frame
);

  logic                          valid_r;
  logic [cfd_pkg::OIDX_W-1:0]    index_r;
  logic [cfd_pkg::VAL_W-1:0]     value_r;
  logic [cfd_pkg::OCNT_W-1:0]    frame_n_r;
  logic                          last_r;

  assign out_free = !valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (out_free) begin
      valid_r <= load.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load.valid && out_free) begin
      index_r   <= load.index;
      value_r   <= rd_data;
      frame_n_r <= load.frame_n;
      last_r    <= load.last;
    end
  end

  assign out_valid          = valid_r;
  assign out_channel_index  = index_r;
  assign out_channel_value  = value_r;
  assign out_frame_channels = frame_n_r;
  assign out_last_in_frame  = last_r;

endmodule
`default_nettype wire

### hw/rtl/cppm_frame_decoder.sv
// CPPM frame decoder: turns capture events into per-channel frame results.
// Input channel (in_valid / in_stall): one capture event per item; in_action
// selects pulse captured, timer overflow or falling edge, and the pulse width
// and period are used only for a captured pulse. Output channel (out_valid /
// out_stall): one item per channel of a finished frame, in channel order,
// with the frame size and a last mark on the final channel.
// Configuration port: cfg_write_en writes cfg_data into the register chosen
// by cfg_index (0 sync_min, 1 input_min, 2 input_max); write only when idle.
// Readout: an item that does not end a frame leaves in_stall low, so the
// next item can follow right behind it. A sync pulse with n stored channels
// holds in_stall high while the store is read out one channel at a time: a
// read of the channel store (ST_READ), then a load of the output register
// (ST_LOAD); the next channel is read only after that result is loaded.
// A stalled output freezes the readout with the pending data held; the next
// input item is taken as soon as the last result sits in the output register.
// Reset (rst_n low, synchronous) restores the default thresholds and clears
// the channel count, the overflow flag and the output valid. The channel
// store itself is not cleared; only entries written since are read out.
`default_nettype none
module cppm_frame_decoder (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [cfd_pkg::ACT_W-1:0]         in_action,
  input  wire logic [cfd_pkg::VAL_W-1:0]         in_pulse_width,
  input  wire logic [cfd_pkg::VAL_W-1:0]         in_pulse_period,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic      [cfd_pkg::OIDX_W-1:0]        out_channel_index,
  output logic      [cfd_pkg::VAL_W-1:0]         out_channel_value,
  output logic      [cfd_pkg::OCNT_W-1:0]        out_frame_channels,
  output logic                                   out_last_in_frame,
  input  wire logic                              cfg_write_en,
  input  wire logic [cfd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [cfd_pkg::VAL_W-1:0]         cfg_data
);

  `include "cppm_frame_decoder_assert.svh"

  cfd_pkg::cfg_t                cfg_r;
  cfd_pkg::ram_req_t            ram_req;
  cfd_pkg::load_t               load;
  cfd_pkg::stat_t               stat;
  logic [cfd_pkg::VAL_W-1:0]    rd_data;
  logic                         out_free;

  // Threshold registers; writes to an unused index are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sync_min  <= cfd_pkg::SYNC_MIN_RST;
      cfg_r.input_min <= cfd_pkg::INPUT_MIN_RST;
      cfg_r.input_max <= cfd_pkg::INPUT_MAX_RST;
    end else if (cfg_write_en) begin
      case (cfg_index)
        cfd_pkg::CFG_SYNC_MIN:  cfg_r.sync_min  <= cfg_data;
        cfd_pkg::CFG_INPUT_MIN: cfg_r.input_min <= cfg_data;
        cfd_pkg::CFG_INPUT_MAX: cfg_r.input_max <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Hold off new items during a frame readout.
  assign in_stall = stat.busy;

  cfd_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .in_valid        (in_valid),
    .in_action       (in_action),
    .in_pulse_width  (in_pulse_width),
    .in_pulse_period (in_pulse_period),
    .out_free        (out_free),
    .ram_req         (ram_req),
    .load            (load),
    .stat            (stat)
  );

  // Channel store: written at the channel count, read during readout only,
  // so a write and a read never meet in the same cycle.
  cfd_ram #(
    .DEPTH (cfd_pkg::STORE_CAP),
    .WIDTH (cfd_pkg::VAL_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_req.wr_en),
    .wr_addr (ram_req.wr_addr),
    .wr_data (ram_req.wr_data),
    .rd_en   (ram_req.rd_en),
    .rd_addr (ram_req.rd_addr),
    .rd_data (rd_data)
  );

  cfd_out u_out (
    .clk                (clk),
    .rst_n              (rst_n),
    .load               (load),
    .rd_data            (rd_data),
    .out_stall          (out_stall),
    .out_free           (out_free),
    .out_valid          (out_valid),
    .out_channel_index  (out_channel_index),
    .out_channel_value  (out_channel_value),
    .out_frame_channels (out_frame_channels),
    .out_last_in_frame  (out_last_in_frame)
  );

  // The count is cleared as soon as a readout begins.
  `CFD_ASSERT_NOW(a_busy_count_clear, stat.busy, stat.count_zero, "count not clear during readout")
  // Every result lies inside its frame.
  `CFD_ASSERT_NOW(a_index_in_frame, out_valid, (4'(out_channel_index) < out_frame_channels), "channel index beyond frame size")
  // The last mark sits on the final channel and nowhere else.
  `CFD_ASSERT_NOW(a_last_mark, out_valid, (out_last_in_frame == ((4'(out_channel_index) + 4'd1) == out_frame_channels)), "last mark misplaced")
  // Never load a result into an occupied output slot.
  `CFD_ASSERT_NEXT(a_load_needs_free, (load.valid && !out_free), 1'b0, "load into an occupied output slot")

endmodule
`default_nettype wire

### tb/sv/cppm_frame_decoder_test.sv
`default_nettype none
module cppm_frame_decoder_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Action code three has no meaning in the block; the decoder must ignore it.
  localparam logic [cfd_pkg::ACT_W-1:0] ACT_UNUSED = 2'd3;

  // One channel result as the output port presents it.
  typedef struct packed {
    logic [cfd_pkg::OIDX_W-1:0] index;
    logic [cfd_pkg::VAL_W-1:0]  value;
    logic [cfd_pkg::OCNT_W-1:0] count;
    logic                       last;
  } chan_result_t;

  // Directed row: fixed rows carry their expected frame right here (none or a
  // single channel); the other rows are left to the frame predictor.
  typedef struct {
    logic [cfd_pkg::ACT_W-1:0] act;
    logic [cfd_pkg::VAL_W-1:0] width;
    logic [cfd_pkg::VAL_W-1:0] period;
    bit                        fixed;
    bit                        one_chan;
    logic [cfd_pkg::VAL_W-1:0] chan_val;
  } stim_row_t;

  // Threshold setting for one phase and the number of items sent under it.
  typedef struct {
    logic [cfd_pkg::VAL_W-1:0] sync_min;
    logic [cfd_pkg::VAL_W-1:0] in_min;
    logic [cfd_pkg::VAL_W-1:0] in_max;
    int                        items;
  } setting_t;

  typedef enum {RX_FREE, RX_RANDOM, RX_PATTERN, RX_HOLD} rx_mode_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                          in_valid;
  logic                          in_stall;
  logic [cfd_pkg::ACT_W-1:0]     in_action;
  logic [cfd_pkg::VAL_W-1:0]     in_pulse_width;
  logic [cfd_pkg::VAL_W-1:0]     in_pulse_period;
  logic                          out_valid;
  logic                          out_stall;
  logic [cfd_pkg::OIDX_W-1:0]    out_channel_index;
  logic [cfd_pkg::VAL_W-1:0]     out_channel_value;
  logic [cfd_pkg::OCNT_W-1:0]    out_frame_channels;
  logic                          out_last_in_frame;
  logic                          cfg_write_en;
  logic [cfd_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [cfd_pkg::VAL_W-1:0]     cfg_data;

  cppm_frame_decoder uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_action          (in_action),
    .in_pulse_width     (in_pulse_width),
    .in_pulse_period    (in_pulse_period),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_channel_index  (out_channel_index),
    .out_channel_value  (out_channel_value),
    .out_frame_channels (out_frame_channels),
    .out_last_in_frame  (out_last_in_frame),
    .cfg_write_en       (cfg_write_en),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always #5 clk = ~clk;

  // Frame predictor state: thresholds, captured channels, overflow flag.
  logic [cfd_pkg::VAL_W-1:0] sync_min_r = cfd_pkg::SYNC_MIN_RST;
  logic [cfd_pkg::VAL_W-1:0] in_min_r   = cfd_pkg::INPUT_MIN_RST;
  logic [cfd_pkg::VAL_W-1:0] in_max_r   = cfd_pkg::INPUT_MAX_RST;
  logic [cfd_pkg::VAL_W-1:0] cap_store [8];
  logic [3:0]                cap_count = 4'd0;
  bit                        ovf_flag = 1'b0;

  // Channels the predictor released for the item just taken, and the
  // channels still owed by the block, oldest first.
  chan_result_t fresh_chans [$];
  chan_result_t pending_chans [$];

  // Expected frame of the directed row on the input port.
  bit                        row_fixed = 1'b0;
  bit                        row_one_chan = 1'b0;
  logic [cfd_pkg::VAL_W-1:0] row_chan_val = '0;

  int mismatches = 0;
  int sent_items = 0;
  int burst_left = 0;

  stim_row_t directed_rows [25] = '{
    // sync on an empty store: nothing comes out
    '{cfd_pkg::ACT_PULSE,    16'd3000,  16'd0,     1'b1, 1'b0, 16'd0},
    // window edges, width one below sync
    '{cfd_pkg::ACT_PULSE,    16'd400,   16'd800,   1'b1, 1'b0, 16'd0},
    '{cfd_pkg::ACT_PULSE,    16'd2999,  16'd2200,  1'b1, 1'b0, 16'd0},
    // widest sync reads out both
    '{cfd_pkg::ACT_PULSE,    16'hFFFF,  16'hFFFF,  1'b0, 1'b0, 16'd0},
    '{cfd_pkg::ACT_PULSE,    16'd0,     16'd1500,  1'b1, 1'b0, 16'd0},
    '{cfd_pkg::ACT_PULSE,    16'd3000,  16'd0,     1'b1, 1'b1, 16'd1500},
    // period above the window drops the count
    '{cfd_pkg::ACT_PULSE,    16'd0,     16'd1000,  1'b1, 1'b0, 16'd0},
    '{cfd_pkg::ACT_PULSE,    16'd0,     16'd2201,  1'b1, 1'b0, 16'd0},
    '{cfd_pkg::ACT_PULSE,    16'd3000,  16'd0,     1'b1, 1'b0, 16'd0},
    // period below the window drops the count, capture restarts
    '{cfd_pkg::ACT_PULSE,    16'd0,     16'd1000,  1'b1, 1'b0, 16'd0},
    '{cfd_pkg::ACT_PULSE,    16'd0,     16'd799,   1'b1, 1'b0, 16'd0},
    '{cfd_pkg::ACT_PULSE,    16'd0,     16'd1234,  1'b1, 1'b0, 16'd0},
    '{cfd_pkg::ACT_PULSE,    16'd3000,  16'hFFFF,  1'b1, 1'b1, 16'd1234},
    // overflow spoils the next pulse
    '{cfd_pkg::ACT_OVERFLOW, 16'hFFFF,  16'hFFFF,  1'b1, 1'b0, 16'd0},
    '{cfd_pkg::ACT_PULSE,    16'd0,     16'd1200,  1'b1, 1'b0, 16'd0},
    '{cfd_pkg::ACT_PULSE,    16'd3000,  16'd0,     1'b1, 1'b0, 16'd0},
    // repeated overflow, falling edge drops the count, flag stays for sync
    '{cfd_pkg::ACT_PULSE,    16'd0,     16'd1100,  1'b1, 1'b0, 16'd0},
    '{cfd_pkg::ACT_OVERFLOW, 16'd0,     16'd0,     1'b1, 1'b0, 16'd0},
    '{cfd_pkg::ACT_OVERFLOW, 16'd0,     16'd0,     1'b1, 1'b0, 16'd0},
    '{cfd_pkg::ACT_FALL,     16'd0,     16'd0,     1'b1, 1'b0, 16'd0},
    '{cfd_pkg::ACT_PULSE,    16'd3000,  16'd0,     1'b1, 1'b0, 16'd0},
    // falling edge without overflow and the unused code keep the count
    '{cfd_pkg::ACT_PULSE,    16'd0,     16'd1300,  1'b1, 1'b0, 16'd0},
    '{cfd_pkg::ACT_FALL,     16'hFFFF,  16'hFFFF,  1'b1, 1'b0, 16'd0},
    '{ACT_UNUSED,            16'hFFFF,  16'hFFFF,  1'b1, 1'b0, 16'd0},
    '{cfd_pkg::ACT_PULSE,    16'd3000,  16'd0,     1'b1, 1'b1, 16'd1300}
  };

  setting_t settings [6] = '{
    '{cfd_pkg::SYNC_MIN_RST, cfd_pkg::INPUT_MIN_RST, cfd_pkg::INPUT_MAX_RST, 50},
    '{16'hFFFF,              16'd0,                  16'hFFFF,               50},
    '{16'd0,                 16'hFFFF,               16'd0,                  20},
    '{16'd2500,              16'd1500,               16'd1500,               50},
    '{16'd4000,              16'd3000,               16'd1000,               25},
    '{16'd3000,              16'd900,                16'd2100,               50}
  };

  // Apply one capture event to the predictor; released channels land in
  // fresh_chans.
  function automatic void decode_event(input logic [cfd_pkg::ACT_W-1:0] act,
                                       input logic [cfd_pkg::VAL_W-1:0] width,
                                       input logic [cfd_pkg::VAL_W-1:0] period);
    fresh_chans.delete();
    case (act)
      cfd_pkg::ACT_PULSE: begin
        if (ovf_flag) begin
          cap_count = 4'd0;
        end else if (width >= sync_min_r) begin
          // Sync: read out every captured channel, then start over.
          for (int k = 0; k < cap_count; k++) begin
            fresh_chans.push_back('{cfd_pkg::OIDX_W'(k), cap_store[k], cap_count,
                                    (k + 1 == cap_count)});
          end
          cap_count = 4'd0;
        end else if (period >= in_min_r && period <= in_max_r) begin
          // Drop channels beyond the store, keep the count.
          if (cap_count < cfd_pkg::STORE_CAP) begin
            cap_store[cap_count[2:0]] = period;
            cap_count++;
          end
        end else begin
          cap_count = 4'd0;
        end
        ovf_flag = 1'b0;
      end
      cfd_pkg::ACT_OVERFLOW: ovf_flag = 1'b1;
      cfd_pkg::ACT_FALL: if (ovf_flag) cap_count = 4'd0;
      default: ;
    endcase
  endfunction

  function automatic void check_field(input string name,
                                      input logic [cfd_pkg::VAL_W-1:0] want,
                                      input logic [cfd_pkg::VAL_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Sample both channels at the rising edge: check the result first, so a
  // stray result can never meet an expectation queued at the same edge.
  always @(posedge clk) begin : scoreboard
    chan_result_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_chans.size() == 0) begin
          $display("%0t: result expected none got index %0d value %0d", $time,
                   out_channel_index, out_channel_value);
          mismatches++;
        end else begin
          want = pending_chans.pop_front();
          check_field("channel_index", cfd_pkg::VAL_W'(want.index),
                      cfd_pkg::VAL_W'(out_channel_index));
          check_field("channel_value", want.value, out_channel_value);
          check_field("frame_channels", cfd_pkg::VAL_W'(want.count),
                      cfd_pkg::VAL_W'(out_frame_channels));
          check_field("last_in_frame", cfd_pkg::VAL_W'(want.last),
                      cfd_pkg::VAL_W'(out_last_in_frame));
        end
      end
      if (in_valid && !in_stall) begin
        decode_event(in_action, in_pulse_width, in_pulse_period);
        if (row_fixed) begin
          // Take the typed frame of the directed row instead.
          if (row_one_chan)
            pending_chans.push_back('{'0, row_chan_val, cfd_pkg::OCNT_W'(1), 1'b1});
        end else begin
          foreach (fresh_chans[i]) pending_chans.push_back(fresh_chans[i]);
        end
      end
    end
  end

  // Receiver: rotate through free running, random stalls, a fixed pattern
  // and a long hold-off that lets the decoder back up into its input.
  initial begin : rx_stall_gen
    rx_mode_t mode;
    int       span;
    out_stall = 1'b0;
    mode = RX_FREE;
    @(posedge rst_n);
    forever begin
      span = (mode == RX_HOLD) ? 160 : $urandom_range(30, 120);
      for (int c = 0; c < span; c++) begin
        @(negedge clk);
        case (mode)
          RX_FREE:    out_stall <= 1'b0;
          RX_RANDOM:  out_stall <= ($urandom_range(0, 99) < 40);
          RX_PATTERN: out_stall <= (c % 3 != 0);
          default:    out_stall <= 1'b1;
        endcase
      end
      mode = mode.next();
    end
  end

  function automatic logic [cfd_pkg::VAL_W-1:0] rand16();
    return cfd_pkg::VAL_W'($urandom);
  endfunction

  // Offer one item at the falling edge and hold it until taken. Open a gap
  // with valid low whenever the current burst runs out.
  task automatic send_item(input logic [cfd_pkg::ACT_W-1:0] act,
                           input logic [cfd_pkg::VAL_W-1:0] width,
                           input logic [cfd_pkg::VAL_W-1:0] period);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_action <= act;
    in_pulse_width <= width;
    in_pulse_period <= period;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    if (act != ACT_UNUSED) sent_items++;
  endtask

  // Noise: random events, overflow runs and stray falling edges.
  task automatic send_noise();
    case ($urandom_range(0, 3))
      0: send_item(cfd_pkg::ACT_W'($urandom_range(0, 3)), rand16(), rand16());
      1: begin
        send_item(cfd_pkg::ACT_OVERFLOW, rand16(), rand16());
        if ($urandom_range(0, 1)) send_item(cfd_pkg::ACT_OVERFLOW, rand16(), rand16());
        send_item(cfd_pkg::ACT_FALL, rand16(), rand16());
      end
      2: send_item(cfd_pkg::ACT_OVERFLOW, rand16(), rand16());
      default: send_item(cfd_pkg::ACT_FALL, rand16(), rand16());
    endcase
  endtask

  // Well-formed frame under the current thresholds, now and then broken up
  // by noise; some frames overrun the store.
  task automatic send_frame();
    int                        nch;
    logic [cfd_pkg::VAL_W-1:0] width;
    logic [cfd_pkg::VAL_W-1:0] period;
    nch = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 10) : $urandom_range(1, 8);
    for (int k = 0; k < nch; k++) begin
      if ($urandom_range(0, 14) == 0) send_noise();
      width = (sync_min_r == 0) ? '0
                                : cfd_pkg::VAL_W'($urandom_range(0, sync_min_r - 1));
      period = (in_min_r <= in_max_r) ? cfd_pkg::VAL_W'($urandom_range(in_min_r, in_max_r))
                                      : rand16();
      send_item(cfd_pkg::ACT_PULSE, width, period);
    end
    send_item(cfd_pkg::ACT_PULSE, cfd_pkg::VAL_W'($urandom_range(sync_min_r, 16'hFFFF)),
              rand16());
  endtask

  task automatic write_reg(input logic [cfd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [cfd_pkg::VAL_W-1:0] val);
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_write_en <= 1'b0;
    @(negedge clk);
    case (idx)
      cfd_pkg::CFG_SYNC_MIN:  sync_min_r = val;
      cfd_pkg::CFG_INPUT_MIN: in_min_r = val;
      cfd_pkg::CFG_INPUT_MAX: in_max_r = val;
      default: ;
    endcase
  endtask

  // Go idle: lower valid, wait for every owed channel, then cover the
  // readout time of the decoder.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_chans.size() != 0) @(negedge clk);
    repeat (24) @(negedge clk);
  endtask

  initial begin : stimulus
    int target;
    in_valid = 1'b0;
    in_action = cfd_pkg::ACT_PULSE;
    in_pulse_width = '0;
    in_pulse_period = '0;
    cfg_write_en = 1'b0;
    cfg_index = cfd_pkg::CFG_SYNC_MIN;
    cfg_data = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part under the reset thresholds.
    foreach (directed_rows[i]) begin
      row_fixed = directed_rows[i].fixed;
      row_one_chan = directed_rows[i].one_chan;
      row_chan_val = directed_rows[i].chan_val;
      send_item(directed_rows[i].act, directed_rows[i].width, directed_rows[i].period);
    end
    row_fixed = 1'b0;

    // Random part, one phase per threshold setting; the first keeps reset.
    foreach (settings[s]) begin
      if (s != 0) begin
        drain();
        write_reg(cfd_pkg::CFG_SYNC_MIN, settings[s].sync_min);
        write_reg(cfd_pkg::CFG_INPUT_MIN, settings[s].in_min);
        write_reg(cfd_pkg::CFG_INPUT_MAX, settings[s].in_max);
      end
      target = sent_items + settings[s].items;
      while (sent_items < target) begin
        if ($urandom_range(0, 9) < 8) send_frame();
        else send_noise();
      end
    end

    in_valid <= 1'b0;
    while (pending_chans.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (mismatches == 0) begin
      $display("cppm_frame_decoder_test: clean");
    end else begin
      $display("cppm_frame_decoder_test: errors");
    end
    $finish;
  end

  // Hang guard: far beyond the slowest correct run.
  initial begin : watchdog
    #5_000_000;
    $display("cppm_frame_decoder_test: errors");
    $finish;
  end

endmodule
`default_nettype wire
